FILE: rtl/rmus_pkg.sv
// Package for the RNS modulus up-scale unit: widths, register indexes, reset values.
package rmus_pkg;

   localparam int unsigned DEF_RING_BITS  = 64;
   localparam int unsigned DEF_PRIME_BITS = 60;
   localparam int unsigned CSR_DATA_BITS  = 64;
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned BASE_BITS_W    = 7;
   localparam int unsigned FIELD_Q_W      = 60;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BASE_BITS    = 2'd0,
      CSR_PRIME        = 2'd1,
      CSR_QUOT_RESIDUE = 2'd2,
      CSR_BIG_Q_LOW    = 2'd3
   } csr_index_type;

   localparam logic [BASE_BITS_W-1:0] BASE_BITS_RESET = 7'd64;
   localparam logic [FIELD_Q_W-1:0]   PRIME_RESET     = 60'd3;

endpackage

FILE: rtl/rmus_modred.sv
// Pipelined reduction of a wide value modulo q, a fixed number of bits per stage.
module rmus_modred #(
   parameter int unsigned IN_BITS    = 128,
   parameter int unsigned PRIME_BITS = 60,
   parameter int unsigned STEP_BITS  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [IN_BITS-1:0]    in_value,
   input  logic [PRIME_BITS-1:0] in_q,
   output logic                  out_valid,
   output logic [PRIME_BITS-1:0] out_rem
);
   localparam int unsigned NSTAGE = (IN_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int unsigned PADW   = NSTAGE * STEP_BITS;

   logic [PRIME_BITS-1:0] rem_ff   [NSTAGE+1];
   logic [PADW-1:0]       val_ff   [NSTAGE+1];
   logic [PRIME_BITS-1:0] q_ff     [NSTAGE+1];
   logic                  valid_ff [NSTAGE+1];

   assign rem_ff[0]   = '0;
   assign val_ff[0]   = PADW'(in_value);
   assign q_ff[0]     = in_q;
   assign valid_ff[0] = in_valid;

   for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
      logic [PRIME_BITS:0] r_in;
      always_comb begin
         logic [PRIME_BITS:0] r;
         logic [PRIME_BITS:0] d;
         r = {1'b0, rem_ff[s]};
         for (int b = 0; b < STEP_BITS; b++) begin
            r = {r[PRIME_BITS-1:0], val_ff[s][PADW-1-b]};
            d = r - {1'b0, q_ff[s]};
            if (r >= {1'b0, q_ff[s]}) begin
               r = d;
            end
         end
         r_in = r;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else begin
            valid_ff[s+1] <= valid_ff[s];
         end
         rem_ff[s+1] <= r_in[PRIME_BITS-1:0];
         val_ff[s+1] <= val_ff[s] << STEP_BITS;
         q_ff[s+1]   <= q_ff[s];
      end
   end

   assign out_valid = valid_ff[NSTAGE];
   assign out_rem   = rem_ff[NSTAGE];
endmodule

FILE: rtl/rns_modulus_up_scale_unit.sv
// Top level of the RNS modulus up-scale unit: round(Q*x/2^k) mod q, one word per cycle.
// Throughput: one word per clock cycle, every cycle; start is taken whenever busy is low,
// and busy is tied low since the pipeline never stalls (the receiver cannot hold results).
// Pipeline: from the accepting edge to the edge that takes the result word, the word passes the
// input register, x mod q reduction, two multiplier stages, product mod q reduction and the
// output register.
// Reset: synchronous, active high; clears valid bits and loads register reset values.
module rns_modulus_up_scale_unit #(
   parameter int unsigned RING_BITS  = rmus_pkg::DEF_RING_BITS,
   parameter int unsigned PRIME_BITS = rmus_pkg::DEF_PRIME_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [RING_BITS-1:0]               req_ring_value,
   output logic                               rsp_valid,
   output logic [rmus_pkg::FIELD_Q_W-1:0]     rsp_scaled_residue,
   input  logic                               csr_write,
   input  logic [rmus_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rmus_pkg::CSR_DATA_BITS-1:0] csr_data
);
   localparam int unsigned KW   = rmus_pkg::BASE_BITS_W;
   localparam int unsigned PW   = PRIME_BITS;
   localparam int unsigned RW   = RING_BITS;
   localparam int unsigned PRW  = 2 * RW;      // qlow*x product
   localparam int unsigned UPW  = 2 * PW;      // u*qd product
   localparam int unsigned STEP = 8;

   // Configuration registers.
   logic [KW-1:0]                  base_bits_ff;
   logic [rmus_pkg::FIELD_Q_W-1:0] prime_ff;
   logic [rmus_pkg::FIELD_Q_W-1:0] quot_ff;
   logic [RW-1:0]                  big_q_low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_bits_ff <= rmus_pkg::BASE_BITS_RESET;
         prime_ff     <= rmus_pkg::PRIME_RESET;
         quot_ff      <= '0;
         big_q_low_ff <= '0;
      end else if (csr_write) begin
         unique case (rmus_pkg::csr_index_type'(csr_index))
            rmus_pkg::CSR_BASE_BITS:    base_bits_ff <= csr_data[KW-1:0];
            rmus_pkg::CSR_PRIME:        prime_ff     <= csr_data[rmus_pkg::FIELD_Q_W-1:0];
            rmus_pkg::CSR_QUOT_RESIDUE: quot_ff      <= csr_data[rmus_pkg::FIELD_Q_W-1:0];
            rmus_pkg::CSR_BIG_Q_LOW:    big_q_low_ff <= csr_data[RW-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // Effective ring width, clamped to [2, RING_BITS]; prime and quotient cut to PW bits.
   logic [KW-1:0] k_eff;
   always_comb begin
      k_eff = base_bits_ff;
      if (base_bits_ff < KW'(2)) begin
         k_eff = KW'(2);
      end else if (base_bits_ff > KW'(RW)) begin
         k_eff = KW'(RW);
      end
   end
   logic [RW-1:0] kmask;
   assign kmask = (k_eff >= KW'(RW)) ? {RW{1'b1}} : ~({RW{1'b1}} << k_eff);
   logic [PW-1:0] q_eff;
   logic [PW-1:0] qd_raw;
   assign q_eff  = PW'(prime_ff);
   assign qd_raw = PW'(quot_ff);
   logic degen;
   assign degen = (q_eff < PW'(2));

   // Stage 1: mask input and register.
   logic          s1_valid_ff;
   logic [RW-1:0] s1_x_ff;
   logic [RW-1:0] s1_qlow_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
      s1_x_ff    <= req_ring_value & kmask;
      s1_qlow_ff <= big_q_low_ff & kmask;
   end

   // Reduce x mod q and the quotient residue mod q in parallel pipelines.
   logic          xr_valid;
   logic [PW-1:0] xr;
   logic [PW-1:0] qdr;
   logic          qdr_valid;
   rmus_modred #(.IN_BITS(RW), .PRIME_BITS(PW), .STEP_BITS(STEP)) u_red_x (
      .clock, .reset, .in_valid(s1_valid_ff), .in_value(s1_x_ff), .in_q(q_eff),
      .out_valid(xr_valid), .out_rem(xr)
   );
   rmus_modred #(.IN_BITS(PW), .PRIME_BITS(PW), .STEP_BITS(STEP)) u_red_qd (
      .clock, .reset, .in_valid(s1_valid_ff), .in_value(qd_raw), .in_q(q_eff),
      .out_valid(qdr_valid), .out_rem(qdr)
   );

   // v path: qlow*x split into four 32x32 partial products, then summed and shifted.
   localparam int unsigned HW  = RW / 2;
   localparam int unsigned HW2 = RW - HW;
   logic [2*HW2-1:0] pv_ll_ff, pv_lh_ff, pv_hl_ff, pv_hh_ff;
   logic             pv_valid_ff;
   logic [RW-1:0]    pv_x_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_valid_ff <= 1'b0;
      end else begin
         pv_valid_ff <= s1_valid_ff;
      end
      pv_ll_ff <= (2*HW2)'(s1_qlow_ff[HW-1:0]) * (2*HW2)'(s1_x_ff[HW-1:0]);
      pv_lh_ff <= (2*HW2)'(s1_qlow_ff[HW-1:0]) * (2*HW2)'(s1_x_ff[RW-1:HW]);
      pv_hl_ff <= (2*HW2)'(s1_qlow_ff[RW-1:HW]) * (2*HW2)'(s1_x_ff[HW-1:0]);
      pv_hh_ff <= (2*HW2)'(s1_qlow_ff[RW-1:HW]) * (2*HW2)'(s1_x_ff[RW-1:HW]);
      pv_x_ff  <= s1_x_ff;
   end
   logic [PRW:0]    prod_sum;
   logic [PRW:0]    round_bit;
   logic [PRW:0]    v_full;
   assign prod_sum = (PRW+1)'(pv_ll_ff) + ((PRW+1)'(pv_lh_ff) << HW)
                   + ((PRW+1)'(pv_hl_ff) << HW) + ((PRW+1)'(pv_hh_ff) << (2*HW));
   assign round_bit = (PRW+1)'(1) << (k_eff - KW'(1));
   logic [PRW:0] prod_ff;
   logic         prod_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= pv_valid_ff;
      end
      prod_ff <= prod_sum + round_bit;
   end
   assign v_full = prod_ff >> k_eff;
   logic [RW:0] v_ff;
   logic        v_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v_valid_ff <= 1'b0;
      end else begin
         v_valid_ff <= prod_valid_ff;
      end
      v_ff <= v_full[RW:0];
   end
   // v < 2^RW always holds; reduce it mod q in its own pipeline.
   logic          vr_valid;
   logic [PW-1:0] vr;
   rmus_modred #(.IN_BITS(RW), .PRIME_BITS(PW), .STEP_BITS(STEP)) u_red_v (
      .clock, .reset, .in_valid(v_valid_ff), .in_value(v_ff[RW-1:0]), .in_q(q_eff),
      .out_valid(vr_valid), .out_rem(vr)
   );

   // u path: (x mod q)*(qd mod q) as four partial products, then reduce.
   localparam int unsigned PH  = PW / 2;
   localparam int unsigned PH2 = PW - PH;
   logic [2*PH2-1:0] pu_ll_ff, pu_lh_ff, pu_hl_ff, pu_hh_ff;
   logic             pu_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         pu_valid_ff <= 1'b0;
      end else begin
         pu_valid_ff <= xr_valid & qdr_valid;
      end
      pu_ll_ff <= (2*PH2)'(xr[PH-1:0]) * (2*PH2)'(qdr[PH-1:0]);
      pu_lh_ff <= (2*PH2)'(xr[PH-1:0]) * (2*PH2)'(qdr[PW-1:PH]);
      pu_hl_ff <= (2*PH2)'(xr[PW-1:PH]) * (2*PH2)'(qdr[PH-1:0]);
      pu_hh_ff <= (2*PH2)'(xr[PW-1:PH]) * (2*PH2)'(qdr[PW-1:PH]);
   end
   logic [UPW-1:0] up_ff;
   logic           up_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         up_valid_ff <= 1'b0;
      end else begin
         up_valid_ff <= pu_valid_ff;
      end
      up_ff <= UPW'(pu_ll_ff) + (UPW'(pu_lh_ff) << PH) + (UPW'(pu_hl_ff) << PH)
             + (UPW'(pu_hh_ff) << (2*PH));
   end
   logic          ur_valid;
   logic [PW-1:0] ur;
   rmus_modred #(.IN_BITS(UPW), .PRIME_BITS(PW), .STEP_BITS(STEP)) u_red_u (
      .clock, .reset, .in_valid(up_valid_ff), .in_value(up_ff), .in_q(q_eff),
      .out_valid(ur_valid), .out_rem(ur)
   );

   // Align the v remainder to the u remainder with a delay line.
   localparam int unsigned NX  = (RW + STEP - 1) / STEP;
   localparam int unsigned NU  = (UPW + STEP - 1) / STEP;
   localparam int unsigned LU  = NX + 2 + NU;     // s1 -> ur
   localparam int unsigned LV  = 3 + NX;          // s1 -> vr
   localparam int unsigned DLY = LU - LV;
   logic [PW-1:0] vd_ff [DLY+1];
   assign vd_ff[0] = vr;
   for (genvar d = 0; d < DLY; d++) begin : g_vdly
      always_ff @(posedge clock) begin
         vd_ff[d+1] <= vd_ff[d];
      end
   end

   // Final add and conditional subtract; zero when the prime is below 2.
   logic [PW:0] sum;
   logic [PW:0] sum_sub;
   assign sum     = {1'b0, ur} + {1'b0, vd_ff[DLY]};
   assign sum_sub = sum - {1'b0, q_eff};
   logic          out_valid_ff;
   logic [PW-1:0] out_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= ur_valid & vr_valid | ur_valid;
      end
      if (degen) begin
         out_ff <= '0;
      end else if (sum >= {1'b0, q_eff}) begin
         out_ff <= sum_sub[PW-1:0];
      end else begin
         out_ff <= sum[PW-1:0];
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_scaled_residue = rmus_pkg::FIELD_Q_W'(out_ff);
endmodule

FILE: tb/rmus_checker.sv
// Checker for the RNS modulus up-scale unit: predicts each result word and compares it.
`timescale 1ns / 1ps
module rmus_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic [63:0]                         req_ring_value,
   input  logic                                rsp_valid,
   input  logic [rmus_pkg::FIELD_Q_W-1:0]      rsp_scaled_residue,
   input  logic                                csr_write,
   input  logic [rmus_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rmus_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                  fail_count,
   output int                                  pending_count
);
   logic [6:0]  ring_bits_reg;
   logic [59:0] prime_reg;
   logic [59:0] quot_reg;
   logic [63:0] q_low_reg;
   logic [59:0] residue_queue[$];

   function automatic logic [59:0] scale_up(input logic [63:0] x_in);
      int unsigned   k;
      logic [63:0]   kmask;
      logic [127:0]  q;
      logic [127:0]  x;
      logic [127:0]  u;
      logic [127:0]  v;
      k = ring_bits_reg;
      if (k < 2) k = 2;
      if (k > 64) k = 64;
      kmask = (k == 64) ? '1 : ((64'd1 << k) - 64'd1);
      q = 128'(prime_reg);
      if (q < 2) return '0;
      x = 128'(x_in & kmask);
      u = ((x % q) * (128'(quot_reg) % q)) % q;
      v = (128'(q_low_reg & kmask) * x + (128'd1 << (k - 1))) >> k;
      return 60'((u + v % q) % q);
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         ring_bits_reg <= rmus_pkg::BASE_BITS_RESET;
         prime_reg     <= rmus_pkg::PRIME_RESET;
         quot_reg      <= '0;
         q_low_reg     <= '0;
      end else begin
         // Compare the result word of this cycle before queuing new ones.
         if (rsp_valid) begin
            if (residue_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected word %h", rsp_scaled_residue));
            end else begin
               if (rsp_scaled_residue !== residue_queue[0])
                  report_mismatch($sformatf("scaled_residue got %h want %h",
                                            rsp_scaled_residue, residue_queue[0]));
               void'(residue_queue.pop_front());
            end
         end
         if (start && !busy) residue_queue.push_back(scale_up(req_ring_value));
         if (csr_write) begin
            case (csr_index)
               rmus_pkg::CSR_BASE_BITS:    ring_bits_reg <= csr_data[6:0];
               rmus_pkg::CSR_PRIME:        prime_reg     <= csr_data[59:0];
               rmus_pkg::CSR_QUOT_RESIDUE: quot_reg      <= csr_data[59:0];
               rmus_pkg::CSR_BIG_Q_LOW:    q_low_reg     <= csr_data;
               default: ;
            endcase
         end
      end
      pending_count = residue_queue.size();
   end

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end
endmodule

FILE: tb/tb_rns_modulus_up_scale_unit.sv
// Testbench top for the RNS modulus up-scale unit: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_rns_modulus_up_scale_unit;
   localparam int DRAIN_CYCLES = 40;     // longer than the pipeline latency
   localparam int WATCHDOG_LIMIT = 2000;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic [63:0]                         req_ring_value = '0;
   logic                                rsp_valid;
   logic [rmus_pkg::FIELD_Q_W-1:0]      rsp_scaled_residue;
   logic                                csr_write = 1'b0;
   logic [rmus_pkg::CSR_INDEX_BITS-1:0] csr_index = rmus_pkg::CSR_BASE_BITS;
   logic [rmus_pkg::CSR_DATA_BITS-1:0]  csr_data = '0;
   int                                  fail_count;
   int                                  pending_count;
   int                                  idle_cycles = 0;
   int                                  send_idle_pct = 29;
   logic [6:0]                          cur_k = 7'd64;

   always #10 clock = ~clock;

   rns_modulus_up_scale_unit dut (
      .clock, .reset, .start, .busy, .req_ring_value, .rsp_valid, .rsp_scaled_residue,
      .csr_write, .csr_index, .csr_data
   );

   rmus_checker checker_i (
      .clock, .reset, .start, .busy, .req_ring_value, .rsp_valid, .rsp_scaled_residue,
      .csr_write, .csr_index, .csr_data, .fail_count, .pending_count
   );

   // Watchdog: count cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic write_reg(input rmus_pkg::csr_index_type idx, input logic [63:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Drain all expectations, then wait out the pipeline before touching registers.
   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Present one word; start holds high across back-to-back words.
   task automatic send_word(input logic [63:0] val);
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start          <= 1'b1;
      req_ring_value <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic set_config(input logic [6:0] k, input logic [63:0] q,
                             input logic [63:0] qd, input logic [63:0] ql);
      wait_idle();
      write_reg(rmus_pkg::CSR_BASE_BITS, 64'(k));
      write_reg(rmus_pkg::CSR_PRIME, q);
      write_reg(rmus_pkg::CSR_QUOT_RESIDUE, qd);
      write_reg(rmus_pkg::CSR_BIG_Q_LOW, ql);
      cur_k = k;
   endtask

   // Random x biased toward the ring width and its edges.
   function automatic logic [63:0] pick_x();
      int unsigned sel;
      sel = $urandom_range(9);
      case (sel)
         0: return '0;
         1: return '1;
         2: return (cur_k >= 64) ? '1 : (64'd1 << cur_k) - 64'd1;
         3: return (cur_k >= 64 || cur_k == 0) ? 64'd1 << 63 : 64'd1 << (cur_k - 7'd1);
         default: return rand64();
      endcase
   endfunction

   function automatic logic [63:0] pick_prime();
      int unsigned sel;
      sel = $urandom_range(7);
      case (sel)
         0: return 64'(60'hFFF_FFFF_FFFF_FFFF);
         1: return 64'd2;
         2: return 64'($urandom_range(1));          // degenerate prime
         3: return {4'hF, 60'(rand64() >> 4)};      // bits above 60 cut off
         4: return 64'($urandom_range(1000, 2));
         default: return rand64() >> $urandom_range(4, 60);
      endcase
   endfunction

   function automatic logic [6:0] pick_k();
      int unsigned sel;
      sel = $urandom_range(5);
      case (sel)
         0: return 7'd64;
         1: return 7'd2;
         2: return 7'($urandom_range(127, 65));   // clamps to 64
         3: return 7'($urandom_range(1));        // clamps to 2
         default: return 7'($urandom_range(63, 3));
      endcase
   endfunction

   initial begin
      logic [63:0] directed_x[$];
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset settings first, then extremes of every register.
      directed_x = '{64'd0, 64'd1, '1, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                     64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
      send_idle_pct = 0;
      foreach (directed_x[i]) send_word(directed_x[i]);
      set_config(7'd64, 64'hFFFF_FFFF_FFFF_FFFF, '1, '1);
      foreach (directed_x[i]) send_word(directed_x[i]);
      set_config(7'd2, 64'd2, 64'd5, 64'd3);
      foreach (directed_x[i]) send_word(directed_x[i]);
      set_config(7'd0, 64'd1, 64'd7, 64'd1);   // degenerate prime, k clamps to 2
      send_word('1);
      set_config(7'd127, 64'd0, 64'd0, '1);
      send_word('1);

      // Random phases: sender idles, then runs flat out; registers change between phases.
      for (int phase = 0; phase < 26; phase++) begin
         send_idle_pct = (phase < 9) ? 29 : (phase < 18) ? 77 : 0;
         set_config(pick_k(), pick_prime(), rand64() >> $urandom_range(0, 8), rand64());
         for (int n = 0; n < 50; n++) begin
            send_word(pick_x());
            // Hold off now and then until every expected word is back.
            if (n == 25 && phase % 5 == 0) begin
               @(negedge clock);
               start <= 1'b0;
               while (pending_count != 0) @(negedge clock);
            end
         end
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
